@@ src/u2b_pkg.sv @@
// Shared constants, types and functions of the UYVY to BGR converter.
`default_nettype none

package u2b_pkg;

   // Width of the signed weighted sums; covers -70688 .. 136882.
   localparam int SUM_W = 19;
   localparam int PIX_W = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic signed [SUM_W-1:0] K_Y         = 19'sd298;
   localparam logic signed [SUM_W-1:0] K_RED_V     = 19'sd409;
   localparam logic signed [SUM_W-1:0] K_GREEN_U   = 19'sd100;
   localparam logic signed [SUM_W-1:0] K_GREEN_V   = 19'sd208;
   localparam logic signed [SUM_W-1:0] K_BLUE_U    = 19'sd516;
   localparam logic signed [SUM_W-1:0] K_ROUND     = 19'sd128;
   localparam logic signed [SUM_W-1:0] K_LUMA_OFS  = 19'sd16;
   localparam logic signed [SUM_W-1:0] K_CHROMA_OFS = 19'sd128;
   localparam logic [PIX_W-1:0]        PIX_MAX     = 8'd255;

   // One queued macropixel: chroma terms worked out, lumas kept raw.
   typedef struct packed {
      logic signed [SUM_W-1:0] term_blue;
      logic signed [SUM_W-1:0] term_green;
      logic signed [SUM_W-1:0] term_red;
      logic [PIX_W-1:0]        luma_first;
      logic [PIX_W-1:0]        luma_second;
   } entry_type;

   // Floor shift by 8, then saturate to 0..255.
   function automatic logic [PIX_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
      logic [PIX_W-1:0] res;
      if (sum[SUM_W-1]) begin
         res = '0;
      end else if (|sum[SUM_W-2:16]) begin
         res = PIX_MAX;
      end else begin
         res = sum[15:8];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ src/u2b_front.sv @@
// Front end: accepts a macropixel and forms its chroma terms for the queue.
`default_nettype none

module u2b_front (
   input  wire logic                      start,
   input  wire logic                      queue_full,
   input  wire logic [u2b_pkg::PIX_W-1:0] req_chroma_u,
   input  wire logic [u2b_pkg::PIX_W-1:0] req_luma_first,
   input  wire logic [u2b_pkg::PIX_W-1:0] req_chroma_v,
   input  wire logic [u2b_pkg::PIX_W-1:0] req_luma_second,
   output logic                           busy,
   output logic                           push,
   output u2b_pkg::entry_type             push_entry
);

   logic signed [u2b_pkg::SUM_W-1:0] d_ext;
   logic signed [u2b_pkg::SUM_W-1:0] e_ext;

   always_comb begin
      // center chroma around zero
      d_ext = $signed({{(u2b_pkg::SUM_W-u2b_pkg::PIX_W){1'b0}}, req_chroma_u})
            - u2b_pkg::K_CHROMA_OFS;
      e_ext = $signed({{(u2b_pkg::SUM_W-u2b_pkg::PIX_W){1'b0}}, req_chroma_v})
            - u2b_pkg::K_CHROMA_OFS;

      busy = queue_full;
      push = start && !queue_full;

      push_entry.term_blue   = d_ext * u2b_pkg::K_BLUE_U;
      push_entry.term_green  = -(d_ext * u2b_pkg::K_GREEN_U) - (e_ext * u2b_pkg::K_GREEN_V);
      push_entry.term_red    = e_ext * u2b_pkg::K_RED_V;
      push_entry.luma_first  = req_luma_first;
      push_entry.luma_second = req_luma_second;
   end

endmodule

`default_nettype wire

@@ src/u2b_queue.sv @@
// Short queue of precomputed macropixel entries between front and back ends.
`default_nettype none

module u2b_queue #(
   parameter int DEPTH = u2b_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u2b_pkg::entry_type push_entry,
   input  wire logic               pop,
   output logic                    full,
   output logic                    head_valid,
   output u2b_pkg::entry_type      head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   u2b_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   always_comb begin
      full       = (count_ff == CNT_FULL);
      head_valid = (count_ff != '0);
      head       = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ src/u2b_back.sv @@
// Back end: converts one pixel per cycle from a valid queue head, drives results.
`default_nettype none

module u2b_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      head_valid,
   input  wire u2b_pkg::entry_type        head,
   output logic                           pop,
   output logic                           rsp_strobe,
   output logic [u2b_pkg::PIX_W-1:0]      rsp_blue,
   output logic [u2b_pkg::PIX_W-1:0]      rsp_green,
   output logic [u2b_pkg::PIX_W-1:0]      rsp_red,
   output logic [u2b_pkg::PIX_W-1:0]      rsp_gray,
   output logic                           rsp_last_of_pair
);

   logic                             phase_ff, phase_in;
   logic                             sum_valid_ff, sum_valid_in;
   logic                             sum_last_ff, sum_last_in;
   logic [u2b_pkg::PIX_W-1:0]        sum_gray_ff, sum_gray_in;
   logic signed [u2b_pkg::SUM_W-1:0] sum_blue_ff, sum_blue_in;
   logic signed [u2b_pkg::SUM_W-1:0] sum_green_ff, sum_green_in;
   logic signed [u2b_pkg::SUM_W-1:0] sum_red_ff, sum_red_in;
   logic signed [u2b_pkg::SUM_W-1:0] c_ext;
   logic signed [u2b_pkg::SUM_W-1:0] base;

   logic                             strobe_ff, strobe_in;
   logic [u2b_pkg::PIX_W-1:0]        blue_ff, blue_in;
   logic [u2b_pkg::PIX_W-1:0]        green_ff, green_in;
   logic [u2b_pkg::PIX_W-1:0]        red_ff, red_in;
   logic [u2b_pkg::PIX_W-1:0]        gray_ff, gray_in;
   logic                             last_ff, last_in;

   // sum stage: pick this pixel's luma, add luma and chroma terms
   always_comb begin
      sum_gray_in = phase_ff ? head.luma_second : head.luma_first;
      c_ext = $signed({{(u2b_pkg::SUM_W-u2b_pkg::PIX_W){1'b0}}, sum_gray_in})
            - u2b_pkg::K_LUMA_OFS;
      base  = c_ext * u2b_pkg::K_Y + u2b_pkg::K_ROUND;

      sum_blue_in  = base + head.term_blue;
      sum_green_in = base + head.term_green;
      sum_red_in   = base + head.term_red;
      sum_last_in  = phase_ff;
      sum_valid_in = head_valid;

      phase_in = head_valid ? !phase_ff : phase_ff;
      pop      = head_valid && phase_ff;
   end

   // output stage: saturate and hold for one strobe cycle
   always_comb begin
      strobe_in = sum_valid_ff;
      blue_in   = u2b_pkg::clamp_channel(sum_blue_ff);
      green_in  = u2b_pkg::clamp_channel(sum_green_ff);
      red_in    = u2b_pkg::clamp_channel(sum_red_ff);
      gray_in   = sum_gray_ff;
      last_in   = sum_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         sum_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_valid_ff <= sum_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_blue_ff  <= sum_blue_in;
      sum_green_ff <= sum_green_in;
      sum_red_ff   <= sum_red_in;
      sum_gray_ff  <= sum_gray_in;
      sum_last_ff  <= sum_last_in;
      blue_ff      <= blue_in;
      green_ff     <= green_in;
      red_ff       <= red_in;
      gray_ff      <= gray_in;
      last_ff      <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_green        = green_ff;
   assign rsp_red          = red_ff;
   assign rsp_gray         = gray_ff;
   assign rsp_last_of_pair = last_ff;

endmodule

`default_nettype wire

@@ src/uyvy_to_bgr_converter.sv @@
// Top level of the UYVY 4:2:2 to BGR converter (BT.601 integer form).
`default_nettype none

// A transaction is one packed macropixel (U, Y0, V, Y1), taken at a clock edge
// where start is high and busy is low. Every transaction yields exactly two
// pixel results, the first with rsp_last_of_pair low and the second with it
// high, in back-to-back cycles marked by rsp_strobe. The receiver cannot
// stall: each result is on the rsp_ ports for one cycle only. The back end sets
// the pace, converting one pixel per cycle from the queue head while it holds an
// entry; new transactions are taken while older ones are still converted. With
// an empty queue, a macropixel passes the queue, the sum and output registers to
// its first strobe; busy is high only while all QUEUE_DEPTH entries hold waiting
// macropixels, so from empty a burst of at least QUEUE_DEPTH transactions is
// taken on consecutive cycles. Each channel is (298*(Y-16) + chroma term + 128)
// >> 8, saturated to 0..255; rsp_gray carries the raw luma byte.
module uyvy_to_bgr_converter #(
   parameter int QUEUE_DEPTH = u2b_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [u2b_pkg::PIX_W-1:0] req_chroma_u,
   input  wire logic [u2b_pkg::PIX_W-1:0] req_luma_first,
   input  wire logic [u2b_pkg::PIX_W-1:0] req_chroma_v,
   input  wire logic [u2b_pkg::PIX_W-1:0] req_luma_second,
   output logic                           rsp_strobe,
   output logic [u2b_pkg::PIX_W-1:0]      rsp_blue,
   output logic [u2b_pkg::PIX_W-1:0]      rsp_green,
   output logic [u2b_pkg::PIX_W-1:0]      rsp_red,
   output logic [u2b_pkg::PIX_W-1:0]      rsp_gray,
   output logic                           rsp_last_of_pair
);

   // hand-off between the stages
   logic               queue_full;
   logic               push;
   u2b_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   u2b_pkg::entry_type head;

   // accept and precompute chroma terms shared by both pixels
   u2b_front u_front (
      .start           (start),
      .queue_full      (queue_full),
      .req_chroma_u    (req_chroma_u),
      .req_luma_first  (req_luma_first),
      .req_chroma_v    (req_chroma_v),
      .req_luma_second (req_luma_second),
      .busy            (busy),
      .push            (push),
      .push_entry      (push_entry)
   );

   // decouple intake from the fixed-pace output side
   u2b_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   // two pixels per entry, one per cycle; drop the entry after the second
   u2b_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_gray         (rsp_gray),
      .rsp_last_of_pair (rsp_last_of_pair)
   );

endmodule

`default_nettype wire

@@ src/u2b_checker.sv @@
// Port-level checks of the converter and their binding to the top level.
`default_nettype none

module u2b_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire logic rsp_last_of_pair
);

   // second pixel always directly follows a first pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_pair |-> $past(rsp_strobe && !rsp_last_of_pair))
      else $error("second pixel without a preceding first pixel");

   // first pixel is always followed by its second pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_pair |=> rsp_strobe && rsp_last_of_pair)
      else $error("first pixel not followed by second pixel");

   // reset empties the block
   assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("results or busy after reset");

   // busy only rises after a transaction was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted transaction");

endmodule

bind uyvy_to_bgr_converter u2b_checker u_u2b_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_last_of_pair (rsp_last_of_pair)
);

`default_nettype wire

@@ tb/tb_uyvy_to_bgr_converter.sv @@
// Self-checking testbench for the UYVY 4:2:2 to BGR converter.
`timescale 1ns / 100ps

module tb_uyvy_to_bgr_converter;

   localparam int  PW           = u2b_pkg::PIX_W;
   localparam int  LIMIT_CYCLES = 200_000;
   localparam int  SETTLE_CYCLES = 8;        // first-pixel path, both pixels of the pair, margin
   localparam int  MAX_REPORTS  = 10;

   typedef logic [PW-1:0] pix_type;

   // One converted pixel as it should appear on the rsp_ ports.
   typedef struct {
      pix_type blue;
      pix_type green;
      pix_type red;
      pix_type gray;
      logic    last_of_pair;
   } pixel_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   pix_type req_chroma_u;
   pix_type req_luma_first;
   pix_type req_chroma_v;
   pix_type req_luma_second;
   logic    rsp_strobe;
   pix_type rsp_blue;
   pix_type rsp_green;
   pix_type rsp_red;
   pix_type rsp_gray;
   logic    rsp_last_of_pair;

   // Pixels predicted for accepted macropixels, oldest first.
   pixel_type pending_pixels[$];
   int        error_count = 0;
   int        cycle_count = 0;

   uyvy_to_bgr_converter u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_chroma_u     (req_chroma_u),
      .req_luma_first   (req_luma_first),
      .req_chroma_v     (req_chroma_v),
      .req_luma_second  (req_luma_second),
      .rsp_strobe       (rsp_strobe),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_gray         (rsp_gray),
      .rsp_last_of_pair (rsp_last_of_pair)
   );

   // 20 ns clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Floor-divide a weighted sum by 256 and clip it to the 8-bit range.
   // A negative sum always lands on 0, a quotient above 255 on 255.
   function automatic pix_type saturate_channel(input int sum);
      int q;
      if (sum < 0) return '0;
      q = sum >>> 8;
      if (q > 255) return pix_type'(255);
      return pix_type'(q);
   endfunction

   // BT.601 integer conversion of one pixel; both pixels of a macropixel
   // share the chroma pair, only the luma differs.
   function automatic pixel_type bt601_pixel(input pix_type luma, input pix_type cb,
                                             input pix_type cr, input logic second);
      pixel_type px;
      int        c;
      int        d;
      int        e;
      int        base;
      c    = int'(luma) - 16;
      d    = int'(cb) - 128;
      e    = int'(cr) - 128;
      base = 298 * c + 128;
      px.blue         = saturate_channel(base + 516 * d);
      px.green        = saturate_channel(base - 100 * d - 208 * e);
      px.red          = saturate_channel(base + 409 * e);
      px.gray         = luma;
      px.last_of_pair = second;
      return px;
   endfunction

   // ---------------------------------------------------------------------
   // Checking: every strobed pixel must match the oldest prediction.
   // ---------------------------------------------------------------------

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            flag_error($sformatf("unexpected pixel b=%0d g=%0d r=%0d gray=%0d last=%0b",
                                 rsp_blue, rsp_green, rsp_red, rsp_gray, rsp_last_of_pair));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_blue !== want.blue || rsp_green !== want.green || rsp_red !== want.red ||
                rsp_gray !== want.gray || rsp_last_of_pair !== want.last_of_pair) begin
               flag_error($sformatf({"pixel mismatch: expected b=%0d g=%0d r=%0d gray=%0d ",
                                     "last=%0b, got b=%0d g=%0d r=%0d gray=%0d last=%0b"},
                                    want.blue, want.green, want.red, want.gray,
                                    want.last_of_pair, rsp_blue, rsp_green, rsp_red,
                                    rsp_gray, rsp_last_of_pair));
            end
         end
      end
   end

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Present one macropixel at the falling edge and hold it until the
   // converter takes it (start high, busy low at a rising edge). Start is
   // left high on return so back-to-back transactions never glitch it; the
   // caller drops it through hold_sender when a gap is wanted.
   task automatic send_macropixel(input pix_type cb, input pix_type y0, input pix_type cr,
                                  input pix_type y1);
      @(negedge clock);
      start           = 1'b1;
      req_chroma_u    = cb;
      req_luma_first  = y0;
      req_chroma_v    = cr;
      req_luma_second = y1;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(bt601_pixel(y0, cb, cr, 1'b0));
      pending_pixels.push_back(bt601_pixel(y1, cb, cr, 1'b1));
   endtask

   // Drop start for the given number of cycles.
   task automatic hold_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Drop start and wait until every predicted pixel has come out.
   task automatic drain_converter();
      hold_sender(1);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Byte generator weighted toward the interesting points of the formula:
   // range ends, video black/white levels and the neutral chroma value.
   function automatic pix_type pick_byte();
      case ($urandom_range(0, 9))
         0:       return pix_type'(8'h00);
         1:       return pix_type'(8'hFF);
         2:       return pix_type'(8'd16);
         3:       return pix_type'(8'd235);
         4:       return pix_type'(8'd128);
         default: return pix_type'($urandom);
      endcase
   endfunction

   task automatic send_random_macropixel();
      send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Corners of the formula: range ends of every field, alternating bit
   // patterns, saturation low (negative sum) and high (quotient above 255),
   // and the nominal black, white and gray levels.
   task automatic test_corners();
      send_macropixel(8'h00, 8'h00, 8'h00, 8'h00);   // blue and red far below zero, green in range
      send_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);   // blue and red far above 255, green in range
      send_macropixel(8'd128, 8'd16, 8'd128, 8'd235); // nominal black, then white
      send_macropixel(8'd128, 8'd128, 8'd128, 8'd127);
      send_macropixel(8'hFF, 8'h00, 8'h00, 8'hFF);   // blue pushed up, red pushed down
      send_macropixel(8'h00, 8'hFF, 8'hFF, 8'h00);
      send_macropixel(8'h00, 8'd128, 8'hFF, 8'd128); // green low, red high
      send_macropixel(8'hFF, 8'd128, 8'h00, 8'd128); // green high, blue high
      send_macropixel(8'h55, 8'hAA, 8'h55, 8'hAA);
      send_macropixel(8'hAA, 8'h55, 8'hAA, 8'h55);
      hold_sender(5);
      send_macropixel(8'd128, 8'd15, 8'd128, 8'd16); // just below and at black
      send_macropixel(8'd128, 8'd235, 8'd128, 8'd236);
      send_macropixel(8'd127, 8'd17, 8'd129, 8'd234);
      send_macropixel(8'h01, 8'h80, 8'hFE, 8'h7F);
      send_macropixel(8'hFE, 8'h7F, 8'h01, 8'h80);
      send_macropixel(8'd90, 8'd81, 8'd240, 8'd82);  // saturated red test color
      send_macropixel(8'd54, 8'd145, 8'd34, 8'd144); // saturated green test color
      send_macropixel(8'd240, 8'd41, 8'd110, 8'd40); // saturated blue test color
      drain_converter();
   endtask

   // Offer transactions on every cycle so the queue fills and busy stalls
   // the sender.
   task automatic test_back_to_back();
      repeat (40) send_random_macropixel();
      drain_converter();
   endtask

   // Random macropixels with random sender gaps; every so often let the
   // converter drain completely before continuing.
   task automatic test_random_with_gaps();
      for (int i = 0; i < 480; i++) begin
         if ($urandom_range(0, 2) == 0) hold_sender($urandom_range(1, 19));
         if (i % 120 == 119) drain_converter();
         send_random_macropixel();
      end
   endtask

   // Closing stretch: no gaps at all.
   task automatic test_full_rate();
      repeat (160) send_random_macropixel();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_chroma_u    = '0;
      req_luma_first  = '0;
      req_chroma_v    = '0;
      req_luma_second = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corners();
      test_back_to_back();
      test_random_with_gaps();
      test_full_rate();

      // Drain, then give the back end time to show any stray strobe.
      drain_converter();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) flag_error("predicted pixels never came out");

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/u2b_pkg.sv
src/u2b_front.sv
src/u2b_queue.sv
src/u2b_back.sv
src/uyvy_to_bgr_converter.sv
src/u2b_checker.sv
tb/tb_uyvy_to_bgr_converter.sv
